FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tts check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tts check failed");

`endif

FILE: design/tts_pkg.sv
// types and constants of the tick task scheduler
package tts_pkg;

  localparam int OPCODE_W = 2;
  localparam int TAG_W    = 8;
  localparam int DELAY_W  = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;
  localparam int RUNS_W   = 8;
  localparam int MAX_OUT  = 8;
  localparam int CNT_W    = $clog2(MAX_OUT);

  localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD      = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_DUE   = 2'd2
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] period;
    logic [RUNS_W-1:0]  runs;
  } slot_entry_t;

  typedef struct packed {
    slot_entry_t entry;
    logic        pending;
    logic        set_done;
  } tick_res_t;

endpackage

FILE: design/tts_if.sv
// valid/ready channel interfaces for the command and result streams
interface tts_in_if;
  import tts_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [TAG_W-1:0]    task_tag;
  logic [DELAY_W-1:0]  start_delay;
  logic [DELAY_W-1:0]  period;

  modport source(output valid, output opcode, output task_tag, output start_delay,
                 output period, input ready);
  modport sink(input valid, input opcode, input task_tag, input start_delay,
               input period, output ready);
endinterface

interface tts_out_if;
  import tts_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [TAG_W-1:0]    due_tag;
  logic [RUNS_W-1:0]   run_count;
  logic                last;

  modport source(output valid, output status, output slot, output due_tag,
                 output run_count, output last, input ready);
  modport sink(input valid, input status, input slot, input due_tag,
               input run_count, input last, output ready);
endinterface

FILE: design/tts_tick_alu.sv
// per-slot tick update: countdown, saturating run count and reload
module tts_tick_alu (
  input  tts_pkg::slot_entry_t cur,
  input  logic                 pending,
  output tts_pkg::tick_res_t   res
);
  import tts_pkg::*;

  logic [RUNS_W-1:0] runs_cur;

  // runs read as zero when nothing is pending
  assign runs_cur = pending ? cur.runs : '0;

  always_comb begin
    res.entry       = cur;
    res.entry.runs  = runs_cur;
    res.pending     = pending;
    res.set_done    = 1'b0;
    if (cur.delay != '0) begin
      res.entry.delay = cur.delay - DELAY_W'(1);
    end else begin
      res.pending = 1'b1;
      if (runs_cur != RUNS_MAX) begin
        res.entry.runs = runs_cur + RUNS_W'(1);
      end
      if (cur.period != '0) begin
        res.entry.delay = cur.period;
      end else begin
        res.set_done = 1'b1;
      end
    end
  end

endmodule

FILE: design/tick_task_scheduler.sv
// tick task scheduler: a slot table of timed tasks driven by opcodes
//
// in_if carries one command per transaction (clear, add, tick, dispatch) with
// the tag, start delay and period used by add. out_if carries results: one
// for add (slot taken or table full), one per slot with pending runs for
// dispatch, none for clear and tick; last marks the final one of a command.
// The block takes one command at a time; in_if.ready is high only when idle.
// Clear empties the table as it is taken. Add probes one slot per cycle until
// it finds a free slot or reaches the last one. Tick reads each slot and
// writes it back through one shared update unit, one slot per cycle, behind
// the registered read. Dispatch scans the slots in order and emits one result
// per pending slot, at most 8 results per command; slots beyond that stay pending.
// Results sit in an output register, so a new command can be taken while the
// last result still waits; a stalled out_if holds the sequencer in place
// until the register frees up. Synchronous reset empties the table and the
// output register; the slot memory itself needs no clearing.
module tick_task_scheduler #(
  parameter int NUM_SLOTS = 8
) (
  input logic      clk,
  input logic      rst_n,
  tts_in_if.sink   in_if,
  tts_out_if.source out_if
);
  import tts_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_ADD       = 6'b000010,
    S_TICK      = 6'b000100,
    S_TICK_LAST = 6'b001000,
    S_DSCAN     = 6'b010000,
    S_DEMIT     = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0]  valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0]  done_r, done_nxt;
  logic [NUM_SLOTS-1:0]  pend_r, pend_nxt;
  logic                  stg_vld_r, stg_vld_nxt;
  logic [IDX_W-1:0]      stg_idx_r, stg_idx_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [TAG_W-1:0]      lat_tag_r;
  logic [DELAY_W-1:0]    lat_delay_r;
  logic [DELAY_W-1:0]    lat_period_r;

  slot_entry_t           slot_mem [NUM_SLOTS];
  slot_entry_t           rd_data_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  slot_entry_t           mem_wdata;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [TAG_W-1:0]      out_tag_r, out_tag_nxt;
  logic [RUNS_W-1:0]     out_runs_r, out_runs_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_accept;
  logic                  out_free;
  logic                  emit;
  logic                  tick_active;
  logic                  pend_above;
  logic                  disp_last;
  logic [SLOT_W+IDX_W-1:0] slot_ext;
  logic [SLOT_W-1:0]     idx_slot;
  tick_res_t             tick_res;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // slot field keeps the low bits of the index
  assign slot_ext = {{SLOT_W{1'b0}}, idx_r};
  assign idx_slot = slot_ext[SLOT_W-1:0];

  assign tick_active = stg_vld_r && valid_r[stg_idx_r] && !done_r[stg_idx_r];

  tts_tick_alu u_tick_alu (
    .cur     (rd_data_r),
    .pending (pend_r[stg_idx_r]),
    .res     (tick_res)
  );

  // any slot above the current one still waiting for dispatch
  always_comb begin
    pend_above = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if ((j > int'(idx_r)) && valid_r[j] && pend_r[j]) begin
        pend_above = 1'b1;
      end
    end
  end

  assign disp_last = (cnt_r == CNT_W'(MAX_OUT - 1)) || !pend_above;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    valid_nxt      = valid_r;
    done_nxt       = done_r;
    pend_nxt       = pend_r;
    stg_vld_nxt    = 1'b0;
    stg_idx_nxt    = idx_r;
    cnt_nxt        = cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = rd_data_r;
    emit           = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_tag_nxt    = out_tag_r;
    out_runs_nxt   = out_runs_r;
    out_last_nxt   = out_last_r;

    // write back the slot read in the previous tick cycle
    if (tick_active) begin
      mem_we              = 1'b1;
      mem_waddr           = stg_idx_r;
      mem_wdata           = tick_res.entry;
      pend_nxt[stg_idx_r] = tick_res.pending;
      if (tick_res.set_done) begin
        done_nxt[stg_idx_r] = 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          idx_nxt = '0;
          cnt_nxt = '0;
          case (opcode_t'(in_if.opcode))
            OP_CLEAR: begin
              valid_nxt = '0;
              done_nxt  = '0;
              pend_nxt  = '0;
            end
            OP_ADD:      state_nxt = S_ADD;
            OP_TICK:     state_nxt = S_TICK;
            OP_DISPATCH: state_nxt = S_DSCAN;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (!valid_r[idx_r]) begin
          if (out_free) begin
            mem_we           = 1'b1;
            mem_waddr        = idx_r;
            mem_wdata.tag    = lat_tag_r;
            mem_wdata.delay  = lat_delay_r;
            mem_wdata.period = lat_period_r;
            mem_wdata.runs   = '0;
            valid_nxt[idx_r] = 1'b1;
            done_nxt[idx_r]  = 1'b0;
            pend_nxt[idx_r]  = 1'b0;
            emit             = 1'b1;
            out_status_nxt   = ST_ADDED;
            out_slot_nxt     = idx_slot;
            out_tag_nxt      = '0;
            out_runs_nxt     = '0;
            out_last_nxt     = 1'b1;
            state_nxt        = S_IDLE;
          end
        end else if (idx_r == LAST_IDX) begin
          if (out_free) begin
            emit           = 1'b1;
            out_status_nxt = ST_FULL;
            out_slot_nxt   = '0;
            out_tag_nxt    = '0;
            out_runs_nxt   = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_TICK: begin
        stg_vld_nxt = 1'b1;
        stg_idx_nxt = idx_r;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_TICK_LAST;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_TICK_LAST: begin
        state_nxt = S_IDLE;
      end
      S_DSCAN: begin
        if (valid_r[idx_r] && pend_r[idx_r]) begin
          state_nxt = S_DEMIT;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DEMIT: begin
        if (out_free) begin
          emit            = 1'b1;
          out_status_nxt  = ST_DUE;
          out_slot_nxt    = idx_slot;
          out_tag_nxt     = rd_data_r.tag;
          out_runs_nxt    = rd_data_r.runs;
          out_last_nxt    = disp_last;
          pend_nxt[idx_r] = 1'b0;
          // a fired one-shot task leaves the table here
          if (done_r[idx_r]) begin
            valid_nxt[idx_r] = 1'b0;
            done_nxt[idx_r]  = 1'b0;
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          if (disp_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_DSCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      done_r      <= '0;
      pend_r      <= '0;
      stg_vld_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      done_r      <= done_nxt;
      pend_r      <= pend_nxt;
      stg_vld_r   <= stg_vld_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stg_idx_r    <= stg_idx_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_tag_r    <= out_tag_nxt;
    out_runs_r   <= out_runs_nxt;
    out_last_r   <= out_last_nxt;
    if (in_accept) begin
      lat_tag_r    <= in_if.task_tag;
      lat_delay_r  <= in_if.start_delay;
      lat_period_r <= in_if.period;
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= slot_mem[idx_r];
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_status_r;
  assign out_if.slot      = out_slot_r;
  assign out_if.due_tag   = out_tag_r;
  assign out_if.run_count = out_runs_r;
  assign out_if.last      = out_last_r;

endmodule

FILE: design/tts_checker.sv
// port-level checks for the tick task scheduler, bound to the top level
`include "assert_macros.svh"

module tts_checker (
  input logic       clk,
  input logic       rst_n,
  tts_in_if.sink    in_if,
  tts_out_if.source out_if
);
  import tts_pkg::*;

  logic                                 cmd_taken;
  logic                                 out_stall;
  logic                                 add_plain;
  logic [STATUS_W+SLOT_W+TAG_W+RUNS_W:0] out_payload;

  assign cmd_taken   = in_if.valid && in_if.ready && (in_if.opcode != OP_CLEAR);
  assign out_stall   = out_if.valid && !out_if.ready;
  assign add_plain   = out_if.last && (out_if.due_tag == '0) && (out_if.run_count == '0);
  assign out_payload = {out_if.status, out_if.slot, out_if.due_tag, out_if.run_count,
                        out_if.last};

  // any command but clear takes the block out of idle, so in_if.ready drops
  `TTS_ASSERT_NEXT(a_busy_after_cmd, cmd_taken, !in_if.ready)

  `TTS_ASSERT_NEXT(a_out_hold, out_stall, out_if.valid && $stable(out_payload))

  // add results are single, carry no tag and no count
  `TTS_ASSERT_NOW(a_add_result, out_if.valid && out_if.status != ST_DUE, add_plain)

  `TTS_ASSERT_NOW(a_due_has_runs, out_if.valid && out_if.status == ST_DUE, out_if.run_count != '0)

endmodule

bind tick_task_scheduler tts_checker u_tts_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);
